@@ sv/rst_pkg.sv @@
// ----------------------------------------------------------------------------
// rst_pkg: shared types and constants for the race split timer
// Holds mode and event codes, register indexes and the controller interface.
// ----------------------------------------------------------------------------
package rst_pkg;

  localparam int MaxSplits = 16;
  localparam int GateSlots = 128;
  localparam int SplitIdxW = $clog2(MaxSplits + 1);
  localparam int GateIdxW  = $clog2(GateSlots);
  localparam int UsPerMs   = 1000;

  // Race modes.
  localparam logic [1:0] RM_IDLE     = 2'd0;
  localparam logic [1:0] RM_STAGED   = 2'd1;
  localparam logic [1:0] RM_RACING   = 2'd2;
  localparam logic [1:0] RM_FINISHED = 2'd3;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_STAGE = 2'd1;
  localparam logic [1:0] KIND_GATE  = 2'd2;

  // Gate commands.
  localparam logic [7:0] CMD_START  = 8'd1;
  localparam logic [7:0] CMD_FINISH = 8'd2;
  localparam logic [7:0] CMD_SPLIT  = 8'd3;

  // Result event codes.
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_STAGED    = 4'd1;
  localparam logic [3:0] EV_STAGE_IGN = 4'd2;
  localparam logic [3:0] EV_STARTED   = 4'd3;
  localparam logic [3:0] EV_SPLIT     = 4'd4;
  localparam logic [3:0] EV_SPLIT_OVF = 4'd5;
  localparam logic [3:0] EV_REPLAY    = 4'd6;
  localparam logic [3:0] EV_TOTAL     = 4'd7;
  localparam logic [3:0] EV_IGNORED   = 4'd8;
  localparam logic [3:0] EV_DUP       = 4'd9;
  localparam logic [3:0] EV_BAD_GATE  = 4'd10;
  localparam logic [3:0] EV_STAGE_TO  = 4'd11;
  localparam logic [3:0] EV_HOLD_OVER = 4'd12;

  // Configuration register indexes.
  localparam logic [1:0] REG_STAGING_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_FINISH_HOLD     = 2'd1;
  localparam logic [1:0] REG_GATE_LIMIT      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT,
    ST_REPLAY
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch the input item
    logic       timeout;    // apply timeout check
    logic       div_start;  // start the elapsed divider
    logic       handle;     // apply main event, stage outgoing beat
    logic       replay;     // stage replay beat
    logic       rd_next;    // advance replay read pointer
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       out_busy;   // output register holds an untaken beat
    logic       div_done;
    logic       replay_more;
  } dp_sts_t;

endpackage

@@ sv/rst_if.sv @@
// ----------------------------------------------------------------------------
// rst_if: valid/ready channels for the race split timer
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface rst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] time_us;
  logic [7:0]  command;
  logic [7:0]  gate_id;
  logic [31:0] sequence_req;
  modport source (output valid, mode, time_us, command, gate_id, sequence_req,
                  input ready);
  modport sink (input valid, mode, time_us, command, gate_id, sequence_req,
                output ready);
endinterface

interface rst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [1:0]  race_mode;
  logic [7:0]  split_gate;
  logic [4:0]  split_index;
  logic [31:0] time_ms;
  logic [31:0] finish_stamp;
  logic [4:0]  split_count;
  logic        last;
  modport source (output valid, event_res, race_mode, split_gate, split_index,
                  time_ms, finish_stamp, split_count, last, input ready);
  modport sink (input valid, event_res, race_mode, split_gate, split_index,
                time_ms, finish_stamp, split_count, last, output ready);
endinterface

interface rst_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rst_div.sv @@
// ----------------------------------------------------------------------------
// rst_div: elapsed microseconds to milliseconds
// Divides by the constant 1000 as three 16-bit quotient digits. Each digit
// is worked in two steps: a reciprocal multiply, then the remainder.
// ----------------------------------------------------------------------------
module rst_div
  import rst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  localparam logic [9:0]  Divisor = 10'(UsPerMs);
  // Rounded-up 2^36 / 1000; exact for any partial numerator below 2^26.
  localparam logic [26:0] Recip =
    27'(((64'd1 << 36) + 64'(UsPerMs) - 64'd1) / 64'(UsPerMs));

  logic [47:0] num;
  logic [9:0]  rem;
  logic [31:0] quo;
  logic [15:0] digit;
  logic [1:0]  cnt;
  logic        phase;
  logic        busy;
  logic [15:0] chunk;
  logic [25:0] partial;
  logic [52:0] product;
  logic [25:0] digit_x;

  assign quotient = quo;

  // Dividend digit for the current step, most significant first.
  always_comb begin
    case (cnt)
      2'd0:    chunk = num[47:32];
      2'd1:    chunk = num[31:16];
      default: chunk = num[15:0];
    endcase
  end

  // The remainder is below 1000, so each partial quotient fits 16 bits.
  assign partial = {rem, chunk};
  assign product = 53'(partial) * 53'(Recip);
  assign digit_x = 26'(digit) * 26'(Divisor);

  // Step sequencing: two phases per digit, three digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      phase <= !phase;
      if (phase) begin
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 2'd1;
        end
      end
    end
  end

  // Digit from the reciprocal product, then the remainder it leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      if (!phase) begin
        digit <= product[51:36];
      end else begin
        rem <= 10'(partial - digit_x);
        quo <= {quo[15:0], digit};
      end
    end
  end

endmodule

@@ sv/rst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rst_ctrl: sequencer of the race split timer
// Steps one item through lookup, timeout check, divide, emit and replay.
// ----------------------------------------------------------------------------
module rst_ctrl
  import rst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.div_start = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.out_busy) begin
          cmd.timeout = 1'b1;
          state_next  = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done && !sts.out_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          if (sts.replay_more) begin
            cmd.replay  = 1'b1;
            cmd.rd_next = 1'b1;
            state_next  = ST_REPLAY;
          end else begin
            cmd.handle = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_REPLAY: begin
        state_next = ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/rst_dp.sv @@
// ----------------------------------------------------------------------------
// rst_dp: datapath of the race split timer
// Holds mode, times, sequence table, split store and the output register.
// ----------------------------------------------------------------------------
module rst_dp
  import rst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  rst_in_if.sink     in_ch,
  rst_cfg_if.sink    cfg_ch,
  rst_out_if.source  out_ch
);

  // Configuration registers.
  logic [15:0] stage_wait_ms;
  logic [15:0] finish_hold_ms;
  logic [7:0]  gate_id_limit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_wait_ms  <= 16'd30000;
      finish_hold_ms <= 16'd2000;
      gate_id_limit  <= 8'd100;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STAGING_TIMEOUT: stage_wait_ms  <= cfg_ch.data;
        REG_FINISH_HOLD:     finish_hold_ms <= cfg_ch.data;
        REG_GATE_LIMIT:      gate_id_limit  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Latched item.
  logic [1:0]  it_kind;
  logic [47:0] it_time;
  logic [7:0]  it_cmd;
  logic [7:0]  it_gate;
  logic [31:0] it_seq;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind <= in_ch.mode;
      it_time <= in_ch.time_us;
      it_cmd  <= in_ch.command;
      it_gate <= in_ch.gate_id;
      it_seq  <= in_ch.sequence_req;
    end
  end

  // Sequence table: memory with epoch-free clear via a post-reset sweep-less
  // valid bit per entry (128 entries).
  logic [31:0]          seq_mem [GateSlots];
  logic [GateSlots-1:0] seq_vld;
  logic [31:0]          seq_rd;
  logic                 seq_rd_vld;
  logic [GateIdxW-1:0]  gidx;
  logic                 seq_we;

  assign gidx = it_gate[GateIdxW-1:0];

  always_ff @(posedge clk) begin
    seq_rd <= seq_mem[gidx];
    if (seq_we) begin
      seq_mem[gidx] <= it_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_vld    <= '0;
      seq_rd_vld <= 1'b0;
    end else begin
      seq_rd_vld <= seq_vld[gidx];
      if (seq_we) begin
        seq_vld[gidx] <= 1'b1;
      end
    end
  end

  // Elapsed divider.
  logic [31:0] elapsed_ms;
  logic [47:0] start_time;
  logic        div_done;

  rst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (it_time - start_time),
    .done     (div_done),
    .quotient (elapsed_ms)
  );

  // Deadline products, registered before use.
  logic [47:0] stage_dl;
  logic [47:0] hold_dl;

  always_ff @(posedge clk) begin
    stage_dl <= it_time + 48'(stage_wait_ms * 26'(UsPerMs));
    hold_dl  <= it_time + 48'(finish_hold_ms * 26'(UsPerMs));
  end

  // Split store, no reset.
  logic [7:0]           st_gate [MaxSplits];
  logic [31:0]          st_time [MaxSplits];
  logic [SplitIdxW-1:0] stored_count;
  logic [SplitIdxW-1:0] rd_ptr;
  logic [7:0]           rd_gate;
  logic [31:0]          rd_time;
  logic                 st_we;

  always_ff @(posedge clk) begin
    rd_gate <= st_gate[rd_ptr[$clog2(MaxSplits)-1:0]];
    rd_time <= st_time[rd_ptr[$clog2(MaxSplits)-1:0]];
    if (st_we) begin
      st_gate[stored_count[$clog2(MaxSplits)-1:0]] <= it_gate;
      st_time[stored_count[$clog2(MaxSplits)-1:0]] <= elapsed_ms;
    end
  end

  // Decode of the main event.
  logic [1:0]  race_mode;
  logic [47:0] deadline;
  logic        to_pend;
  logic        bad_gate;
  logic        dup;
  logic        is_finish;

  assign bad_gate = ({1'b0, it_gate} >= {1'b0, gate_id_limit})
                 || ({1'b0, it_gate} >= 9'(GateSlots));
  assign dup = seq_rd_vld ? (it_seq <= seq_rd) : (it_seq == 32'd0);
  assign is_finish = (it_kind == KIND_GATE) && !bad_gate && !dup
                  && (it_cmd == CMD_FINISH) && (race_mode == RM_RACING);
  assign seq_we = cmd.handle && (it_kind == KIND_GATE) && !bad_gate && !dup;
  assign st_we  = cmd.handle && (it_kind == KIND_GATE) && !bad_gate && !dup
               && (it_cmd == CMD_SPLIT) && (race_mode == RM_RACING)
               && (stored_count < SplitIdxW'(MaxSplits));

  // Output register.
  logic        ov;
  logic [3:0]  o_ev;
  logic [1:0]  o_mode;
  logic [7:0]  o_gate;
  logic [4:0]  o_idx;
  logic [31:0] o_tms;
  logic [31:0] o_sess;
  logic [4:0]  o_cnt;
  logic        o_last;

  assign out_ch.valid        = ov;
  assign out_ch.event_res    = o_ev;
  assign out_ch.race_mode    = o_mode;
  assign out_ch.split_gate   = o_gate;
  assign out_ch.split_index  = o_idx;
  assign out_ch.time_ms      = o_tms;
  assign out_ch.finish_stamp = o_sess;
  assign out_ch.split_count  = o_cnt;
  assign out_ch.last         = o_last;

  assign sts.out_busy    = ov && !out_ch.ready;
  assign sts.div_done    = div_done;
  assign sts.replay_more = is_finish && (rd_ptr < stored_count);

  // Mode, timers and result beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      race_mode    <= RM_IDLE;
      start_time   <= '0;
      deadline     <= '0;
      stored_count <= '0;
      rd_ptr       <= '0;
      to_pend      <= 1'b0;
      ov           <= 1'b0;
    end else begin
      if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end
      if (cmd.capture) begin
        rd_ptr  <= '0;
        to_pend <= 1'b0;
      end
      if (cmd.rd_next) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      // Timeout beat.
      if (cmd.timeout && it_time >= deadline
          && (race_mode == RM_STAGED || race_mode == RM_FINISHED)) begin
        race_mode <= RM_IDLE;
        to_pend   <= 1'b1;
        ov        <= 1'b1;
        o_ev      <= (race_mode == RM_STAGED) ? EV_STAGE_TO : EV_HOLD_OVER;
        o_mode    <= RM_IDLE;
        o_gate    <= '0;
        o_idx     <= '0;
        o_tms     <= '0;
        o_sess    <= '0;
        o_cnt     <= stored_count;
        o_last    <= (it_kind == KIND_TICK) || (it_kind == 2'd3);
      end
      // Replay beat; the read data was fetched in the previous cycle.
      if (cmd.replay) begin
        ov     <= 1'b1;
        o_ev   <= EV_REPLAY;
        o_mode <= RM_FINISHED;
        o_gate <= rd_gate;
        o_idx  <= rd_ptr;
        o_tms  <= rd_time;
        o_sess <= '0;
        o_cnt  <= stored_count;
        o_last <= 1'b0;
      end
      // Main event beat.
      if (cmd.handle) begin
        o_gate <= '0;
        o_idx  <= '0;
        o_tms  <= '0;
        o_sess <= '0;
        o_last <= 1'b1;
        o_mode <= race_mode;
        o_cnt  <= stored_count;
        ov     <= 1'b1;
        if (it_kind == KIND_STAGE) begin
          if (race_mode == RM_IDLE) begin
            race_mode <= RM_STAGED;
            o_mode    <= RM_STAGED;
            deadline  <= stage_dl;
            o_ev      <= EV_STAGED;
          end else begin
            o_ev <= EV_STAGE_IGN;
          end
        end else if (it_kind == KIND_GATE) begin
          if (bad_gate) begin
            o_ev <= EV_BAD_GATE;
          end else if (dup) begin
            o_ev <= EV_DUP;
          end else if (it_cmd == CMD_START && race_mode == RM_STAGED) begin
            start_time   <= it_time;
            race_mode    <= RM_RACING;
            o_mode       <= RM_RACING;
            stored_count <= '0;
            o_cnt        <= '0;
            o_ev         <= EV_STARTED;
          end else if (it_cmd == CMD_SPLIT && race_mode == RM_RACING) begin
            o_gate <= it_gate;
            o_tms  <= elapsed_ms;
            if (stored_count < SplitIdxW'(MaxSplits)) begin
              stored_count <= stored_count + 1'b1;
              o_cnt        <= stored_count + 1'b1;
              o_idx        <= stored_count;
              o_ev         <= EV_SPLIT;
            end else begin
              o_idx <= SplitIdxW'(MaxSplits);
              o_ev  <= EV_SPLIT_OVF;
            end
          end else if (is_finish) begin
            race_mode <= RM_FINISHED;
            o_mode    <= RM_FINISHED;
            deadline  <= hold_dl;
            o_tms     <= elapsed_ms;
            o_sess    <= it_time[31:0];
            o_ev      <= EV_TOTAL;
          end else begin
            o_ev <= EV_IGNORED;
          end
        end else begin
          // A tick after a timeout beat has nothing more to say.
          ov   <= !to_pend;
          o_ev <= EV_NONE;
        end
      end
    end
  end

endmodule

@@ sv/race_split_timer.sv @@
// ----------------------------------------------------------------------------
// race_split_timer: four-mode race timer with gate splits
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each item goes through capture, lookup, timeout check, the divide by 1000
// (done as three 16-bit digits by reciprocal multiplication), emit and the
// return to ready. A finish also replays every stored split, and stalls on
// the result side add to the time an item takes. Items are handled one at a
// time; the input channel is ready only between items. Configuration writes
// are always taken. The per-gate sequence table starts cleared through valid
// bits.
module race_split_timer
  import rst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rst_in_if.sink    in_ch,
  rst_cfg_if.sink   cfg_ch,
  rst_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rst_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
